// ----- rtl/oap_pkg.sv -----
// Shared types and constants of the oversampling converter packetizer.
`default_nettype none

package oap_pkg;

  localparam int REQ_W      = 2;
  localparam int SHIFT_W    = 3;
  localparam int BYTE_W     = 8;
  localparam int RESULT_W   = 16;
  localparam int CHAN_OUT_W = 2;

  localparam logic [BYTE_W-1:0]  HEADER_BYTE = 8'hAA;
  localparam logic [BYTE_W-1:0]  PAD_BYTE    = 8'h00;
  localparam logic [SHIFT_W-1:0] RESET_SHIFT = 3'd3;

  typedef enum logic [REQ_W-1:0] {
    REQ_SAMPLE  = 2'd0,
    REQ_READ    = 2'd1,
    REQ_RELEASE = 2'd2
  } req_t;

  typedef struct packed {
    logic do_sample;
    logic do_read;
    logic do_release;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0]     byte_out;
    logic                  byte_valid;
    logic                  frame_ready;
    logic [CHAN_OUT_W-1:0] next_channel;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/oap_fifo.sv -----
// Small register queue with a fill count, used as the request queue and the result queue of the packetizer.
`default_nettype none

module oap_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/oap_front.sv -----
// Front stage: accepts request items, decodes the request code and queues them.
`default_nettype none

module oap_front #(
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [oap_pkg::REQ_W-1:0]      req_type,
  input  wire logic [SAMPLE_BITS-1:0]         sample_value,
  output logic                                q_valid,
  output oap_pkg::cmd_t                       q_cmd,
  output logic      [SAMPLE_BITS-1:0]         q_sample,
  input  wire logic                           q_pop
);

  localparam int CMD_W   = $bits(oap_pkg::cmd_t);
  localparam int ENTRY_W = CMD_W + SAMPLE_BITS;

  oap_pkg::cmd_t      cmd;
  logic [ENTRY_W-1:0] entry_in;
  logic [ENTRY_W-1:0] entry_out;
  logic               q_empty;

  always_comb begin
    cmd = '0;
    unique case (oap_pkg::req_t'(req_type))
      oap_pkg::REQ_SAMPLE:  cmd.do_sample  = 1'b1;
      oap_pkg::REQ_READ:    cmd.do_read    = 1'b1;
      oap_pkg::REQ_RELEASE: cmd.do_release = 1'b1;
      default:              cmd = '0;
    endcase
  end

  assign entry_in = {cmd, sample_value};

  oap_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (2)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (entry_in),
    .full  (full),
    .pop   (q_pop),
    .rdata (entry_out),
    .empty (q_empty)
  );

  assign q_valid  = !q_empty;
  assign q_cmd    = oap_pkg::cmd_t'(entry_out[ENTRY_W-1:SAMPLE_BITS]);
  assign q_sample = entry_out[SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

// ----- rtl/oap_back.sv -----
// Back stage: oversampling accumulator, packet store, SPI byte source and result queue.
`default_nettype none

module oap_back #(
  parameter int NUM_CHANNELS = 4,
  parameter int SAMPLE_BITS  = 10,
  parameter int MAX_SHIFT    = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [oap_pkg::SHIFT_W-1:0]   oversample_shift,
  input  wire logic                          q_valid,
  input  wire oap_pkg::cmd_t                 q_cmd,
  input  wire logic [SAMPLE_BITS-1:0]        q_sample,
  output logic                               q_pop,
  input  wire logic                          pop,
  output logic                               empty,
  output oap_pkg::result_t                   result
);

  localparam int PACKET_LEN = 2 * NUM_CHANNELS + 2;
  localparam int CHECK_POS  = 2 * NUM_CHANNELS + 1;
  localparam int STORE_LEN  = 2 * NUM_CHANNELS;
  localparam int SUM_W      = SAMPLE_BITS + 2 * MAX_SHIFT;
  localparam int CNT_W      = 2 * MAX_SHIFT + 1;
  localparam int CH_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SI_W       = $clog2(STORE_LEN);
  localparam int RI_W       = $clog2(PACKET_LEN + 1);
  localparam int RES_W      = $bits(oap_pkg::result_t);
  localparam int BW         = oap_pkg::BYTE_W;

  logic [SUM_W-1:0]  sum_acc;
  logic [SUM_W-1:0]  sum_acc_next;
  logic [CNT_W-1:0]  sample_count;
  logic [CNT_W-1:0]  sample_count_next;
  logic [CH_W-1:0]   channel_index;
  logic [CH_W-1:0]   channel_index_next;
  logic [RI_W-1:0]   read_index;
  logic [RI_W-1:0]   read_index_next;
  logic              packet_ready;
  logic              packet_ready_next;
  logic [BW-1:0]     checksum;
  logic [BW-1:0]     checksum_next;
  logic [BW-1:0]     packet_store [STORE_LEN];

  logic [oap_pkg::SHIFT_W-1:0]  eff_shift;
  logic [SUM_W-1:0]             sum_inc;
  logic [CNT_W-1:0]             count_inc;
  logic [CNT_W-1:0]             target;
  logic [SUM_W-1:0]             shifted;
  logic [oap_pkg::RESULT_W-1:0] chan_result;
  logic                         chan_done;
  logic                         store_we;
  logic [SI_W-1:0]              store_idx;
  logic [BW-1:0]                read_byte;
  logic                         out_full_q;
  logic                         step;
  oap_pkg::result_t             res_next;
  logic [RES_W-1:0]             res_bits;

  assign step  = q_valid && !out_full_q;
  assign q_pop = step;

  assign eff_shift   = (oversample_shift > oap_pkg::SHIFT_W'(MAX_SHIFT)) ?
                       oap_pkg::SHIFT_W'(MAX_SHIFT) : oversample_shift;
  assign sum_inc     = sum_acc + SUM_W'(q_sample);
  assign count_inc   = sample_count + 1'b1;
  assign target      = CNT_W'(1) << {eff_shift, 1'b0};
  assign chan_done   = (count_inc >= target);
  assign shifted     = sum_inc >> eff_shift;
  assign chan_result = oap_pkg::RESULT_W'(shifted);
  assign store_idx   = SI_W'({channel_index, 1'b0});

  always_comb begin
    if (read_index == '0) begin
      read_byte = oap_pkg::HEADER_BYTE;
    end else if (read_index == RI_W'(CHECK_POS)) begin
      read_byte = checksum;
    end else begin
      read_byte = packet_store[SI_W'(read_index - 1'b1)];
    end
  end

  always_comb begin
    sum_acc_next       = sum_acc;
    sample_count_next  = sample_count;
    channel_index_next = channel_index;
    read_index_next    = read_index;
    packet_ready_next  = packet_ready;
    checksum_next      = checksum;
    store_we           = 1'b0;
    res_next           = '0;
    if (q_cmd.do_sample && !packet_ready) begin
      sum_acc_next      = sum_inc;
      sample_count_next = count_inc;
      if (chan_done) begin
        store_we          = 1'b1;
        sum_acc_next      = '0;
        sample_count_next = '0;
        checksum_next     = checksum ^ chan_result[BW-1:0] ^ chan_result[2*BW-1:BW];
        if (channel_index == CH_W'(NUM_CHANNELS - 1)) begin
          channel_index_next = '0;
          packet_ready_next  = 1'b1;
          read_index_next    = '0;
        end else begin
          channel_index_next = channel_index + 1'b1;
        end
      end
    end else if (q_cmd.do_read) begin
      res_next.byte_valid = 1'b1;
      if (packet_ready && read_index < RI_W'(PACKET_LEN)) begin
        res_next.byte_out = read_byte;
        read_index_next   = read_index + 1'b1;
      end else begin
        res_next.byte_out = oap_pkg::PAD_BYTE;
      end
    end else if (q_cmd.do_release && packet_ready) begin
      packet_ready_next  = 1'b0;
      read_index_next    = RI_W'(PACKET_LEN);
      sum_acc_next       = '0;
      sample_count_next  = '0;
      channel_index_next = '0;
      checksum_next      = oap_pkg::HEADER_BYTE;
    end
    res_next.frame_ready  = packet_ready_next;
    res_next.next_channel = oap_pkg::CHAN_OUT_W'(channel_index_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc       <= '0;
      sample_count  <= '0;
      channel_index <= '0;
      read_index    <= RI_W'(PACKET_LEN);
      packet_ready  <= 1'b0;
      checksum      <= oap_pkg::HEADER_BYTE;
    end else if (step) begin
      sum_acc       <= sum_acc_next;
      sample_count  <= sample_count_next;
      channel_index <= channel_index_next;
      read_index    <= read_index_next;
      packet_ready  <= packet_ready_next;
      checksum      <= checksum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && store_we) begin
      packet_store[store_idx]                <= chan_result[BW-1:0];
      packet_store[SI_W'(store_idx + 1'b1)]  <= chan_result[2*BW-1:BW];
    end
  end

  oap_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (step),
    .wdata (res_next),
    .full  (out_full_q),
    .pop   (pop),
    .rdata (res_bits),
    .empty (empty)
  );

  assign result = oap_pkg::result_t'(res_bits);

endmodule

`default_nettype wire

// ----- rtl/oversampling_adc_packetizer_top.sv -----
// Top level of the oversampling converter packetizer with its shift register.
//
// Channel   Handshake           Payload
// request   push / full         req_type, sample_value
// result    empty / pop         byte_out, byte_valid, frame_ready, next_channel
// config    cfg_we              cfg_wdata (oversample_shift)
//
// Every request item yields one result item; one item completes per cycle
// while the result queue is not full. A request is registered in the request
// queue and its result in the result queue, from which pop takes it. The
// accumulator step and the packet store access both take place between the two.
// rst is synchronous and active high; a stalled result queue backs up into
// the request queue, which then raises full.
`default_nettype none

module oversampling_adc_packetizer_top #(
  parameter int NUM_CHANNELS = 4,
  parameter int SAMPLE_BITS  = 10,
  parameter int MAX_SHIFT    = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [oap_pkg::REQ_W-1:0]        req_type,
  input  wire logic [SAMPLE_BITS-1:0]           sample_value,
  input  wire logic                             pop,
  output logic                                  empty,
  output logic      [oap_pkg::BYTE_W-1:0]       byte_out,
  output logic                                  byte_valid,
  output logic                                  frame_ready,
  output logic      [oap_pkg::CHAN_OUT_W-1:0]   next_channel,
  input  wire logic                             cfg_we,
  input  wire logic [oap_pkg::SHIFT_W-1:0]      cfg_wdata
);

  logic [oap_pkg::SHIFT_W-1:0] oversample_shift;
  logic                        q_valid;
  oap_pkg::cmd_t               q_cmd;
  logic [SAMPLE_BITS-1:0]      q_sample;
  logic                        q_pop;
  oap_pkg::result_t            result;

  always_ff @(posedge clk) begin
    if (rst) begin
      oversample_shift <= oap_pkg::RESET_SHIFT;
    end else if (cfg_we) begin
      oversample_shift <= cfg_wdata;
    end
  end

  oap_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .req_type     (req_type),
    .sample_value (sample_value),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_sample     (q_sample),
    .q_pop        (q_pop)
  );

  oap_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .MAX_SHIFT    (MAX_SHIFT)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .oversample_shift (oversample_shift),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_sample         (q_sample),
    .q_pop            (q_pop),
    .pop              (pop),
    .empty            (empty),
    .result           (result)
  );

  assign byte_out     = result.byte_out;
  assign byte_valid   = result.byte_valid;
  assign frame_ready  = result.frame_ready;
  assign next_channel = result.next_channel;

endmodule

`default_nettype wire
